// ===== hdl/bpc_pkg.sv =====
`default_nettype none
package bpc_pkg;

   // raw converter reading
   localparam int SAMPLE_WIDTH = 24;
   localparam int SAMPLE_BITS = 24;
   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MASK =
      SAMPLE_WIDTH'((25'd1 << SAMPLE_BITS) - 25'd1);

   // temperature difference, reset value
   localparam int DT_WIDTH = 25;
   localparam logic signed [DT_WIDTH-1:0] DT_RESET = 25'sd68;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SENS_BASE        = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OFFSET_BASE      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SENS_TEMP_COEF   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OFFSET_TEMP_COEF = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_REF_TEMPERATURE  = 3'd4;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // pressure result
   localparam int PRESSURE_WIDTH = 32;

   typedef enum logic {
      OP_TEMPERATURE = 1'b0,
      OP_PRESSURE    = 1'b1
   } kind_type;

   // calibration words
   typedef struct packed {
      logic [CSR_DATA_WIDTH-1:0] sens_base;
      logic [CSR_DATA_WIDTH-1:0] offset_base;
      logic [CSR_DATA_WIDTH-1:0] sens_temp_coef;
      logic [CSR_DATA_WIDTH-1:0] offset_temp_coef;
      logic [CSR_DATA_WIDTH-1:0] ref_temperature;
   } calib_type;

   // classified word: difference for temperature, masked sample for pressure
   typedef struct packed {
      kind_type                   kind;
      logic signed [DT_WIDTH-1:0] value;
   } bpc_word_type;

endpackage
`default_nettype wire

// ===== hdl/bpc_req_if.sv =====
`default_nettype none
interface bpc_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [23:0] sample;

   modport source (output valid, output opcode, output sample, input ready);
   modport sink (input valid, input opcode, input sample, output ready);
endinterface
`default_nettype wire

// ===== hdl/bpc_rsp_if.sv =====
`default_nettype none
interface bpc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pressure;

   modport source (output valid, output pressure, input ready);
   modport sink (input valid, input pressure, output ready);
endinterface
`default_nettype wire

// ===== hdl/bpc_front.sv =====
`default_nettype none
module bpc_front import bpc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   bpc_req_if.sink      req,
   input  wire calib_type calib,
   output logic         push_valid,
   input  wire logic    push_ready,
   output bpc_word_type push_word
);

   logic                      valid_ff, valid_in;
   bpc_word_type              word_ff, word_in;
   logic [SAMPLE_WIDTH-1:0]   sample_masked;
   logic signed [DT_WIDTH-1:0] ref_scaled;

   assign req.ready = !valid_ff || push_ready;

   // classify: temperature words carry dT, pressure words the sample
   always_comb begin
      sample_masked = req.sample & SAMPLE_MASK;
      ref_scaled = $signed({1'b0, calib.ref_temperature, 8'h00});
      if (req.opcode == OP_PRESSURE) begin
         word_in.kind = OP_PRESSURE;
         word_in.value = $signed({1'b0, sample_masked});
      end else begin
         word_in.kind = OP_TEMPERATURE;
         word_in.value = $signed({1'b0, sample_masked}) - ref_scaled;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (req.valid && req.ready) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         word_ff <= word_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_word = word_ff;

endmodule
`default_nettype wire

// ===== hdl/bpc_queue.sv =====
`default_nettype none
module bpc_queue import bpc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire bpc_word_type push_word,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output bpc_word_type pop_word
);

   bpc_word_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic                        do_push, do_pop;

   assign push_ready = count_ff != QUEUE_COUNT_BITS'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_word = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/bpc_back.sv =====
`default_nettype none
module bpc_back import bpc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire calib_type calib,
   input  wire logic    pop_valid,
   output logic         pop_ready,
   input  wire bpc_word_type pop_word,
   bpc_rsp_if.source    rsp
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_OFF  = 8'b0000_0010,
      ST_SENS = 8'b0000_0100,
      ST_SUM  = 8'b0000_1000,
      ST_LO   = 8'b0001_0000,
      ST_HI   = 8'b0010_0000,
      ST_ACC  = 8'b0100_0000,
      ST_OUT  = 8'b1000_0000
   } state_type;

   state_type                   state_ff, state_in;
   logic signed [DT_WIDTH-1:0]  dt_ff;
   logic [SAMPLE_WIDTH-1:0]     sample_ff;
   logic signed [42:0]          prod_ff, prod_in;
   logic signed [34:0]          off_ff;
   logic signed [33:0]          sens_ff;
   logic signed [57:0]          acc_ff;
   logic                        out_valid_ff, out_valid_in;
   logic signed [PRESSURE_WIDTH-1:0] out_ff;
   logic signed [24:0]          mul_a;
   logic signed [17:0]          mul_b;
   logic signed [36:0]          scaled;
   logic signed [37:0]          diff;
   logic signed [22:0]          result;
   logic                        out_free;

   assign pop_ready = state_ff == ST_IDLE;
   assign out_free = !out_valid_ff || rsp.ready;

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_OFF: begin
            mul_a = dt_ff;
            mul_b = $signed({2'b00, calib.offset_temp_coef});
         end
         ST_SENS: begin
            mul_a = dt_ff;
            mul_b = $signed({2'b00, calib.sens_temp_coef});
         end
         ST_LO: begin
            mul_a = $signed({1'b0, sample_ff});
            mul_b = $signed({1'b0, sens_ff[16:0]});
         end
         ST_HI: begin
            mul_a = $signed({1'b0, sample_ff});
            mul_b = $signed({sens_ff[33], sens_ff[33:17]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = 43'(mul_a * mul_b);
   end

   // final shift, subtract, shift
   always_comb begin
      scaled = 37'(acc_ff >>> 21);
      diff = 38'(scaled) - 38'(off_ff);
      result = 23'(diff >>> 15);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid && pop_word.kind == OP_PRESSURE) begin
               state_in = ST_OFF;
            end
         end
         ST_OFF:  state_in = ST_SENS;
         ST_SENS: state_in = ST_SUM;
         ST_SUM:  state_in = ST_LO;
         ST_LO:   state_in = ST_HI;
         ST_HI:   state_in = ST_ACC;
         ST_ACC:  state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (state_ff == ST_OUT && out_free) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         dt_ff <= DT_RESET;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         if (state_ff == ST_IDLE && pop_valid && pop_word.kind == OP_TEMPERATURE) begin
            dt_ff <= pop_word.value;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (state_ff)
         ST_IDLE: begin
            sample_ff <= pop_word.value[SAMPLE_WIDTH-1:0];
         end
         ST_SENS: begin
            off_ff <= $signed({3'b000, calib.offset_base, 16'h0000}) + 35'(prod_ff >>> 7);
         end
         ST_SUM: begin
            sens_ff <= $signed({3'b000, calib.sens_base, 15'h0000}) + 34'(prod_ff >>> 8);
         end
         ST_HI: begin
            acc_ff <= 58'(prod_ff);
         end
         ST_ACC: begin
            acc_ff <= acc_ff + (58'(prod_ff) <<< 17);
         end
         ST_OUT: begin
            if (out_free) begin
               out_ff <= PRESSURE_WIDTH'(result);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.pressure = out_ff;

endmodule
`default_nettype wire

// ===== hdl/barometer_pressure_compensation_core.sv =====
// channel | dir | payload              | handshake
// req     | in  | opcode, sample[23:0] | valid/ready
// rsp     | out | pressure[31:0] signed | valid/ready
// csr     | in  | index[2:0], data[15:0] | write enable
//
// A temperature word is taken by the back end straight from idle; a pressure
// word walks the seven sequencer steps after the pop, sharing the one 25x18
// multiplier stepped through four products. Front stage and a two-word
// queue let input be taken while the back end works or the result stalls.
// Reset is synchronous; calibration clears to zero and dT starts at 68.
`default_nettype none
module barometer_pressure_compensation_core import bpc_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   bpc_req_if.sink                         req,
   bpc_rsp_if.source                       rsp,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   calib_type    calib_ff;
   logic         push_valid, push_ready;
   bpc_word_type push_word;
   logic         pop_valid, pop_ready;
   bpc_word_type pop_word;

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         calib_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_SENS_BASE:        calib_ff.sens_base <= csr_write_data;
            REG_OFFSET_BASE:      calib_ff.offset_base <= csr_write_data;
            REG_SENS_TEMP_COEF:   calib_ff.sens_temp_coef <= csr_write_data;
            REG_OFFSET_TEMP_COEF: calib_ff.offset_temp_coef <= csr_write_data;
            REG_REF_TEMPERATURE:  calib_ff.ref_temperature <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   bpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .calib      (calib_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word)
   );

   bpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word)
   );

   bpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .calib     (calib_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_word  (pop_word),
      .rsp       (rsp)
   );

endmodule
`default_nettype wire

// ===== tb/tb_barometer_pressure_compensation_core.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_barometer_pressure_compensation_core;
   import bpc_pkg::*;

   localparam int SETTLE_CYCLES = 16;
   localparam int LIMIT_CYCLES = 200000;

   typedef struct {
      kind_type          kind;
      logic [23:0]       raw;
   } baro_word_type;

   logic clock;
   logic reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   bpc_req_if req_bus ();
   bpc_rsp_if rsp_bus ();

   barometer_pressure_compensation_core dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // shadow of the block: calibration words and stored temperature difference
   calib_type                  cal = '0;
   logic signed [DT_WIDTH-1:0] temp_diff = DT_RESET;

   baro_word_type      pending_words[$];
   logic signed [31:0] expected_pressures[$];
   int  queued_count = 0;
   int  accepted_count = 0;
   int  error_count = 0;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   bit  idle_on = 1;
   bit  req_fire = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // first-order compensation of one pressure reading
   function automatic logic signed [31:0] compensate(logic [23:0] raw);
      longint s, dt, c1, c2, c3, c4, offs, sens, p;
      s = longint'(raw & SAMPLE_MASK);
      dt = longint'(temp_diff);
      c1 = longint'(cal.sens_base);
      c2 = longint'(cal.offset_base);
      c3 = longint'(cal.sens_temp_coef);
      c4 = longint'(cal.offset_temp_coef);
      offs = (c2 <<< 16) + ((c4 * dt) >>> 7);
      sens = (c1 <<< 15) + ((c3 * dt) >>> 8);
      p = (((s * sens) >>> 21) - offs) >>> 15;
      return p[31:0];
   endfunction

   // temperature words update dT, pressure words expect one result
   task automatic model_word(kind_type kind, logic [23:0] raw);
      longint d;
      if (kind == OP_TEMPERATURE) begin
         d = longint'(raw & SAMPLE_MASK) - (longint'(cal.ref_temperature) <<< 8);
         temp_diff = d[DT_WIDTH-1:0];
      end else begin
         expected_pressures.push_back(compensate(raw));
      end
   endtask

   task automatic push_word(kind_type kind, logic [23:0] raw);
      baro_word_type w;
      w.kind = kind;
      w.raw = raw;
      pending_words.push_back(w);
      queued_count++;
   endtask

   // write all five calibration words back to back; block must be idle
   task automatic write_calib(logic [15:0] c1, logic [15:0] c2, logic [15:0] c3,
                              logic [15:0] c4, logic [15:0] c5);
      logic [CSR_INDEX_WIDTH-1:0] regs [5];
      logic [15:0]                vals [5];
      regs = '{REG_SENS_BASE, REG_OFFSET_BASE, REG_SENS_TEMP_COEF,
               REG_OFFSET_TEMP_COEF, REG_REF_TEMPERATURE};
      vals = '{c1, c2, c3, c4, c5};
      for (int i = 0; i < 5; i++) begin
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_index <= regs[i];
         csr_write_data <= vals[i];
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cal = '{c1, c2, c3, c4, c5};
   endtask

   // all words taken, all results back, then let in-flight temperature words finish
   task automatic wait_idle();
      while (accepted_count != queued_count || expected_pressures.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [15:0] rand_coef();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   function automatic logic [23:0] rand_raw();
      case ($urandom_range(0, 9))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         2, 3: return 24'($urandom_range(6000000, 9000000));
         default: return 24'($urandom_range(0, 24'hFFFFFF));
      endcase
   endfunction

   // request driver: one word per handshake, random gaps between words
   always @(negedge clock) begin : req_driver
      baro_word_type w;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.opcode <= w.kind;
            req_bus.sample <= w.raw;
            if (idle_on && $urandom_range(0, 3) == 0)
               send_gap = $urandom_range(1, 9);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result backpressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (idle_on && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 9);
      end
   end

   // monitor: check results, then predict from accepted words
   always @(posedge clock) begin
      req_fire <= !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_pressures.size() == 0) begin
               $error("pressure: unexpected word %0d", rsp_bus.pressure);
               error_count++;
            end else if (rsp_bus.pressure !== expected_pressures[0]) begin
               $error("pressure: expected %0d, got %0d",
                      expected_pressures[0], rsp_bus.pressure);
               error_count++;
               void'(expected_pressures.pop_front());
            end else begin
               void'(expected_pressures.pop_front());
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            accepted_count++;
            model_word(kind_type'(req_bus.opcode), req_bus.sample);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // stimulus
   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = REG_SENS_BASE;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_TEMPERATURE;
      req_bus.sample = '0;
      rsp_bus.ready = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // typical calibration; pressure before any temperature word uses reset dT
      write_calib(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464);
      push_word(OP_PRESSURE, 24'h000000);
      push_word(OP_PRESSURE, 24'hFFFFFF);
      push_word(OP_PRESSURE, 24'd6465444);
      push_word(OP_TEMPERATURE, 24'd8077636);
      push_word(OP_PRESSURE, 24'd6465444);
      push_word(OP_PRESSURE, 24'h000000);
      push_word(OP_TEMPERATURE, 24'h000000);
      push_word(OP_PRESSURE, 24'hFFFFFF);
      push_word(OP_TEMPERATURE, 24'hFFFFFF);
      push_word(OP_PRESSURE, 24'hFFFFFF);
      push_word(OP_PRESSURE, 24'h800000);
      wait_idle();

      // all words at full scale: most negative dT
      write_calib(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_word(OP_TEMPERATURE, 24'h000000);
      push_word(OP_PRESSURE, 24'hFFFFFF);
      push_word(OP_PRESSURE, 24'h000000);
      push_word(OP_TEMPERATURE, 24'hFFFFFF);
      push_word(OP_PRESSURE, 24'hFFFFFF);
      wait_idle();

      // zero reference temperature: most positive dT
      write_calib(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
      push_word(OP_TEMPERATURE, 24'hFFFFFF);
      push_word(OP_PRESSURE, 24'hFFFFFF);
      push_word(OP_TEMPERATURE, 24'h000000);
      push_word(OP_PRESSURE, 24'hFFFFFF);
      wait_idle();

      // all calibration cleared
      write_calib(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_word(OP_PRESSURE, 24'h123456);
      push_word(OP_TEMPERATURE, 24'hFFFFFF);
      push_word(OP_PRESSURE, 24'hFFFFFF);
      wait_idle();

      // random phases, each with its own calibration; last one runs flat out
      for (int ph = 0; ph < 5; ph++) begin
         idle_on = (ph != 4);
         write_calib(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
         for (int n = 0; n < 100; n++)
            push_word(($urandom_range(0, 2) == 0) ? OP_TEMPERATURE : OP_PRESSURE,
                      rand_raw());
         wait_idle();
      end

      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/bpc_pkg.sv
hdl/bpc_req_if.sv
hdl/bpc_rsp_if.sv
hdl/bpc_front.sv
hdl/bpc_queue.sv
hdl/bpc_back.sv
hdl/barometer_pressure_compensation_core.sv
tb/tb_barometer_pressure_compensation_core.sv
